// ----- rtl/core/nss_pkg.sv -----
// Shared types and constants for the naive substring search unit.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

  // Capacity of each string store, in bytes.
  localparam int MAX_LEN = 256;
  // Store address width and byte-count width (the count must hold MAX_LEN itself).
  localparam int AW      = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  // Width of the position field on the result port.
  localparam int POS_W   = 9;

  // Input command codes.
  localparam logic CMD_TEXT    = 1'b0;
  localparam logic CMD_PATTERN = 1'b1;

  // Two's complement sign of the text versus pattern compare.
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP_RD,
    S_CMP_CHK,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DONE
  } nss_state_t;

  // Search request from the loader to the sequencer.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] text_len;
    logic [CNT_W-1:0] pat_len;
  } nss_req_t;

  // Search result from the sequencer to the output stage.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [1:0]       order;
  } nss_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/nss_seq.sv -----
// Search sequencer: one shared byte comparator stepped over both stores.
// Depends on nss_pkg; store read ports live in the top level.
`timescale 1ns / 1ps
`default_nettype none

module nss_seq
  import nss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire nss_req_t    req,
  input  wire logic [7:0]  text_rd,
  input  wire logic [7:0]  pat_rd,
  input  wire logic        res_take,
  output logic [AW-1:0]    text_addr,
  output logic [AW-1:0]    pat_addr,
  output logic             res_valid,
  output nss_result_t      res
);

  nss_state_t       state, state_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] s, s_next;
  logic [1:0]       order, order_next;
  logic             found, found_next;
  logic [POS_W-1:0] pos, pos_next;

  logic [CNT_W-1:0] tc, pc, n_min, k_inc, s_end;
  logic [1:0]       len_order;
  logic             eq, gt;

  assign tc        = req.text_len;
  assign pc        = req.pat_len;
  assign n_min     = (tc < pc) ? tc : pc;
  assign len_order = (tc > pc) ? ORD_GT : ((tc < pc) ? ORD_LT : ORD_EQ);
  assign k_inc     = k + CNT_W'(1);
  assign s_end     = s + pc;

  // The shared comparator.
  assign eq = (text_rd == pat_rd);
  assign gt = (text_rd > pat_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    k     <= k_next;
    s     <= s_next;
    order <= order_next;
    found <= found_next;
    pos   <= pos_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          state_next = (n_min == '0) ? S_SRCH_INIT : S_CMP_RD;
        end
      end
      S_CMP_RD:  state_next = S_CMP_CHK;
      S_CMP_CHK: begin
        state_next = (!eq || k_inc == n_min) ? S_SRCH_INIT : S_CMP_RD;
      end
      S_SRCH_INIT: begin
        state_next = (pc > tc || pc == '0) ? S_DONE : S_SRCH_RD;
      end
      S_SRCH_RD: state_next = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (eq) begin
          state_next = (k_inc == pc) ? S_DONE : S_SRCH_RD;
        end else begin
          state_next = (s_end == tc) ? S_DONE : S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    text_addr    = AW'(s + k);
    pat_addr     = AW'(k);
    res_valid    = (state == S_DONE);
    res.found    = found;
    res.position = pos;
    res.order    = order;
  end

  always_comb begin
    k_next     = k;
    s_next     = s;
    order_next = order;
    found_next = found;
    pos_next   = pos;
    unique case (state)
      S_IDLE: begin
        k_next = '0;
        s_next = '0;
        if (req.start && n_min == '0) begin
          order_next = len_order;
        end
      end
      S_CMP_CHK: begin
        if (!eq) begin
          order_next = gt ? ORD_GT : ORD_LT;
          k_next     = '0;
        end else if (k_inc == n_min) begin
          order_next = len_order;
          k_next     = '0;
        end else begin
          k_next = k_inc;
        end
      end
      S_SRCH_INIT: begin
        found_next = 1'b0;
        pos_next   = '0;
        k_next     = '0;
        s_next     = '0;
        if (pc <= tc && pc == '0) begin
          found_next = 1'b1;
          pos_next   = POS_W'(1);
        end
      end
      S_SRCH_CHK: begin
        if (eq) begin
          if (k_inc == pc) begin
            found_next = 1'b1;
            pos_next   = POS_W'(s + CNT_W'(1));
          end else begin
            k_next = k_inc;
          end
        end else if (s_end != tc) begin
          s_next = s + CNT_W'(1);
          k_next = '0;
        end
      end
      S_CMP_RD, S_SRCH_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/naive_substring_search_unit.sv -----
// Each byte request is taken whenever in_ready is high. After the closing pattern byte the unit
// is busy while the single byte comparator steps over both stores; each compare takes a read
// state and a check state, for the registered store read.
// The result is then registered at the output; a result still waiting at the output stretches the busy.
// Throughput while loading is one byte a cycle; in_ready is low for the whole search.
// Reset clears counts, flags and valid; store contents are not cleared.
// Top level of the naive substring search unit.
// Depends on nss_pkg and nss_seq; holds both string stores and the result register.
`timescale 1ns / 1ps
`default_nettype none

module naive_substring_search_unit
  import nss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd,
  input  wire logic [7:0]        char_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   found,
  output logic [POS_W-1:0]       position,
  output logic signed [1:0]      order,
  output logic                   overflow
);

  // The two string stores. They are never cleared; nothing beyond the
  // current counts is ever read.
  logic [7:0] text_mem [MAX_LEN];
  logic [7:0] pat_mem  [MAX_LEN];
  logic [7:0] text_rd, pat_rd;

  // Loader state.
  logic [CNT_W-1:0] text_count, pattern_count;
  logic             text_closed;
  logic             dropped;
  logic             busy;

  // Job captured at the closing pattern byte, held while the search runs.
  logic [CNT_W-1:0] job_tc, job_pc;
  logic             job_drop;
  logic             start;

  logic          acc, txt_acc, pat_acc, job_end, text_room, pat_room, res_take;
  logic [AW-1:0] text_addr, pat_addr;
  logic          res_valid;
  nss_req_t      req;
  nss_result_t   res;

  // A request is taken whenever no search is in flight; a result still
  // waiting in the output register does not hold up loading of the next job.
  assign in_ready  = !busy;
  assign acc       = in_valid && in_ready;
  assign text_room = (text_count < CNT_W'(MAX_LEN));
  assign pat_room  = (pattern_count < CNT_W'(MAX_LEN));

  // Text bytes after the text has closed, and pattern bytes before it has,
  // are taken and ignored.
  assign txt_acc = acc && (cmd == CMD_TEXT) && !text_closed;
  assign pat_acc = acc && (cmd == CMD_PATTERN) && text_closed;
  assign job_end = pat_acc && last_byte;

  // Store writes: a byte that finds its store full is dropped.
  always_ff @(posedge clk) begin
    if (txt_acc && text_room) begin
      text_mem[text_count[AW-1:0]] <= char_byte;
    end
    if (pat_acc && pat_room) begin
      pat_mem[pattern_count[AW-1:0]] <= char_byte;
    end
    text_rd <= text_mem[text_addr];
    pat_rd  <= pat_mem[pat_addr];
  end

  // Loader control. At the closing pattern byte the lengths are captured
  // and the counters return to zero at once, so the next job may load as
  // soon as this one's result has left the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_count    <= '0;
      pattern_count <= '0;
      text_closed   <= 1'b0;
      dropped       <= 1'b0;
      busy          <= 1'b0;
      start         <= 1'b0;
    end else begin
      start <= job_end;
      if (txt_acc) begin
        if (text_room) begin
          text_count <= text_count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
        if (last_byte) begin
          text_closed <= 1'b1;
        end
      end
      if (job_end) begin
        text_count    <= '0;
        pattern_count <= '0;
        text_closed   <= 1'b0;
        dropped       <= 1'b0;
        busy          <= 1'b1;
      end else if (pat_acc) begin
        if (pat_room) begin
          pattern_count <= pattern_count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (res_take) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_end) begin
      job_tc   <= text_count;
      job_pc   <= pat_room ? pattern_count + CNT_W'(1) : pattern_count;
      job_drop <= dropped || !pat_room;
    end
  end

  assign req.start    = start;
  assign req.text_len = job_tc;
  assign req.pat_len  = job_pc;

  nss_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .text_rd   (text_rd),
    .pat_rd    (pat_rd),
    .res_take  (res_take),
    .text_addr (text_addr),
    .pat_addr  (pat_addr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: the sequencer hands over its result as soon as the
  // register is empty or is being emptied in the same cycle.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      found    <= res.found;
      position <= res.position;
      order    <= res.order;
      overflow <= job_drop;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nss_checker.sv -----
// Port-level checks for the naive substring search unit, bound to the top level.
// Depends on nss_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module nss_checker
  import nss_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              found,
  input wire logic [POS_W-1:0]  position,
  input wire logic signed [1:0] order,
  input wire logic              overflow
);

  // An offered request stays offered until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before it was taken");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
      && $stable(order) && $stable(overflow))
    else $error("result changed while stalled");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("position set without a match");

  // A hit never reports position zero.
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> position != '0)
    else $error("match reported at position zero");

  // The compare sign is never the unused code.
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> order != 2'sb10)
    else $error("invalid order code");

endmodule

bind naive_substring_search_unit nss_checker u_nss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .position  (position),
  .order     (order),
  .overflow  (overflow)
);

`default_nettype wire
